[hw/rtl/prq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority ready queue package
// Sizes, codes, controller states and the command and status bundles shared
// by the ready queue controller, its datapath and the top level.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Queue geometry and task table size.
    localparam int QUEUE_DEPTH = 6;
    localparam int NUM_TASKS   = 9;

    // Fixed field widths of the channels.
    localparam int OP_W      = 2;
    localparam int ID_W      = 4;
    localparam int PRIO_W    = 4;
    localparam int ENTRIES_W = 3;
    localparam int STATUS_W  = 2;
    localparam int PHASE_W   = 2;

    // Derived widths.
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int TASK_W = $clog2(NUM_TASKS + 1);

    typedef logic [ID_W-1:0]   t_task_id;
    typedef logic [PRIO_W-1:0] t_prio;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [IDX_W-1:0]  t_idx;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_UNLOAD = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_QUEUED = 2'd2,
        ST_BAD_ID     = 2'd3
    } t_status;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_LOADED = 2'd1,
        PH_RUN    = 2'd2
    } t_phase;

    // Operations on the queue register line.
    typedef enum logic [2:0] {
        Q_HOLD,
        Q_ROT,
        Q_DROP,
        Q_PUSH,
        Q_TAIL_ID,
        Q_TAIL_HOLD
    } t_qop;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CHECK,
        S_DROP_HEAD,
        S_SEEK,
        S_REWIND,
        S_PUSH,
        S_TAIL,
        S_DISPATCH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        t_qop    q_op;
        logic    idx_clr;
        logic    idx_inc;
        logic    scan_match;
        logic    scan_max;
        logic    pos_dec;
        logic    load_apply;
        logic    phase_clr;
        logic    set_status;
        t_status status;
        logic    dispatch;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode op;
        logic    id_ok;
        logic    full;
        logic    empty;
        logic    short_q;
        logic    idx_last;
        logic    idx_hit;
        logic    idx_at_cnt;
        logic    found;
    } t_dp_sts;

endpackage
`default_nettype wire

[hw/rtl/prq_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue command channel
// Valid/ready channel that carries one queue command per transaction.
// ----------------------------------------------------------------------------
interface prq_in_if import prq_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_priority_in;

    modport source (output valid, output opcode, output task_id, output task_priority_in,
                    input ready);
    modport sink   (input valid, input opcode, input task_id, input task_priority_in,
                    output ready);
    modport mon    (input valid, input opcode, input task_id, input task_priority_in,
                    input ready);

endinterface
`default_nettype wire

[hw/rtl/prq_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue result channel
// Valid/ready channel that carries one dispatch result per transaction.
// ----------------------------------------------------------------------------
interface prq_out_if import prq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      head_task;
    logic                 first_run;
    logic [ENTRIES_W-1:0] entries;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output head_task, output first_run, output entries,
                    output status, input ready);
    modport sink   (input valid, input head_task, input first_run, input entries,
                    input status, output ready);
    modport mon    (input valid, input head_task, input first_run, input entries,
                    input status, input ready);

endinterface
`default_nettype wire

[hw/rtl/prq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue datapath
// Rotating queue register line with one compare point at its head, the
// per-task priority and phase tables, scan registers and the result register.
// ----------------------------------------------------------------------------
module prq_dp import prq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [ID_W-1:0]      i_task_id,
    input  logic [PRIO_W-1:0]    i_task_priority_in,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [ID_W-1:0]      o_head_task,
    output logic                 o_first_run,
    output logic [ENTRIES_W-1:0] o_entries,
    output logic [STATUS_W-1:0]  o_status
);

    // Captured command.
    t_opcode  r_op;
    t_task_id r_id;
    t_prio    r_prio_in;

    // Queue line and its fill count.
    t_task_id r_slot [QUEUE_DEPTH];
    t_task_id n_slot [QUEUE_DEPTH];
    t_count   r_count;
    t_count   n_count;

    // Walk position, scan results and the two entries taken off the head.
    t_idx     r_idx;
    t_idx     r_pos;
    t_prio    r_best;
    logic     r_found;
    t_task_id r_hold_a;
    t_task_id r_hold_b;

    // Per-task tables, indexed by task id.
    t_prio    r_prio_tab [NUM_TASKS+1];
    t_phase   r_phase    [NUM_TASKS+1];

    // Status of the transaction and the result register.
    t_status  r_status;
    t_task_id r_head;
    logic     r_first;
    logic [ENTRIES_W-1:0] r_entries;
    t_status  r_out_status;

    logic [TASK_W-1:0] w_head_idx;
    logic [TASK_W-1:0] w_id_idx;
    t_prio             w_head_prio;
    logic              w_empty;
    logic              w_head_first;

    assign w_head_idx   = r_slot[0][TASK_W-1:0];
    assign w_id_idx     = r_id[TASK_W-1:0];
    assign w_head_prio  = r_prio_tab[w_head_idx];
    assign w_empty      = (r_count == '0);
    assign w_head_first = !w_empty && (r_phase[w_head_idx] == PH_LOADED);

    // Next state of the queue line: each slot takes a neighbor, the old head, a held entry or the captured id.
    always_comb begin
        n_slot  = r_slot;
        n_count = r_count;
        case (i_cmd.q_op)
            Q_ROT: begin
                // Rotate the occupied part left; the head wraps to the tail.
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    if (CNT_W'(i + 1) < r_count) begin
                        n_slot[i] = r_slot[i+1];
                    end
                end
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (CNT_W'(i + 1) == r_count) begin
                        n_slot[i] = r_slot[0];
                    end
                end
            end
            Q_DROP: begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    n_slot[i] = r_slot[i+1];
                end
                n_count = r_count - CNT_W'(1);
            end
            Q_PUSH: begin
                n_slot[0] = r_hold_a;
                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                    n_slot[i] = r_slot[i-1];
                end
                n_count = r_count + CNT_W'(1);
            end
            Q_TAIL_ID, Q_TAIL_HOLD: begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (CNT_W'(i) == r_count) begin
                        n_slot[i] = (i_cmd.q_op == Q_TAIL_ID) ? r_id : r_hold_b;
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Control state: fill count and task phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int t = 0; t <= NUM_TASKS; t++) begin
                r_phase[t] <= PH_IDLE;
            end
        end else begin
            r_count <= n_count;
            if (i_cmd.load_apply) begin
                r_phase[w_id_idx] <= PH_LOADED;
            end else if (i_cmd.phase_clr) begin
                r_phase[w_id_idx] <= PH_IDLE;
            end else if (i_cmd.dispatch && w_head_first) begin
                r_phase[w_head_idx] <= PH_RUN;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;

        // A new transaction also primes the scan.
        if (i_cmd.capture) begin
            r_op      <= t_opcode'(i_opcode);
            r_id      <= i_task_id;
            r_prio_in <= i_task_priority_in;
            r_pos     <= IDX_W'(1);
            r_best    <= '0;
            r_found   <= 1'b0;
        end else if (i_cmd.scan_match) begin
            // Keep the latest match so the last occurrence wins.
            if (r_slot[0] == r_id) begin
                r_pos   <= r_idx;
                r_found <= 1'b1;
            end
        end else if (i_cmd.scan_max) begin
            // Strictly larger only, so the first of equal priorities wins.
            if ((r_idx != '0) && (w_head_prio > r_best)) begin
                r_pos  <= r_idx;
                r_best <= w_head_prio;
            end
        end else if (i_cmd.pos_dec) begin
            r_pos <= r_pos - IDX_W'(1);
        end

        // Walk position.
        if (i_cmd.capture || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end

        // The two most recent heads taken off the line.
        if (i_cmd.q_op == Q_DROP) begin
            r_hold_a <= r_slot[0];
            r_hold_b <= r_hold_a;
        end

        if (i_cmd.load_apply) begin
            r_prio_tab[w_id_idx] <= r_prio_in;
        end

        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end

        // Result register: the head after the operation.
        if (i_cmd.dispatch) begin
            r_head       <= w_empty ? '0 : r_slot[0];
            r_first      <= w_head_first;
            r_entries    <= ENTRIES_W'(r_count);
            r_out_status <= r_status;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.op         = r_op;
        o_sts.id_ok      = (r_id != '0) && (r_id <= ID_W'(NUM_TASKS));
        o_sts.full       = (r_count == CNT_W'(QUEUE_DEPTH));
        o_sts.empty      = w_empty;
        o_sts.short_q    = (r_count < CNT_W'(2));
        o_sts.idx_last   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_sts.idx_hit    = (r_idx == r_pos);
        o_sts.idx_at_cnt = (CNT_W'(r_idx) == r_count);
        o_sts.found      = r_found;
    end

    assign o_head_task = r_head;
    assign o_first_run = r_first;
    assign o_entries   = r_entries;
    assign o_status    = r_out_status;

endmodule
`default_nettype wire

[hw/rtl/prq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue controller
// Sequences the datapath through scan, seek, drop, rewind and reinsert
// steps as each command needs them and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_unload;

    assign w_unload = (i_sts.op == OP_UNLOAD);

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.q_op = Q_HOLD;
        o_cmd.status = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_DISPATCH;
                case (i_sts.op)
                    OP_LOAD: begin
                        if (!i_sts.id_ok) begin
                            o_cmd.status = ST_BAD_ID;
                        end else if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.q_op       = Q_TAIL_ID;
                            o_cmd.load_apply = 1'b1;
                        end
                    end
                    OP_UNLOAD: begin
                        if (!i_sts.id_ok) begin
                            o_cmd.status = ST_BAD_ID;
                        end else if (i_sts.empty) begin
                            o_cmd.status = ST_NOT_QUEUED;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_TICK: begin
                        if (!i_sts.short_q) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // One full turn of the line, looking at each entry at the head.
                o_cmd.q_op       = Q_ROT;
                o_cmd.scan_match = w_unload;
                o_cmd.scan_max   = !w_unload;
                if (i_sts.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = w_unload ? S_CHECK : S_DROP_HEAD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.found) begin
                    n_state = S_SEEK;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_QUEUED;
                    n_state          = S_DISPATCH;
                end
            end
            S_DROP_HEAD: begin
                // The old head leaves first, so the pick moves one place down.
                o_cmd.q_op    = Q_DROP;
                o_cmd.pos_dec = 1'b1;
                n_state       = S_SEEK;
            end
            S_SEEK: begin
                if (i_sts.idx_hit) begin
                    o_cmd.q_op      = Q_DROP;
                    o_cmd.phase_clr = w_unload;
                    n_state         = S_REWIND;
                end else begin
                    o_cmd.q_op    = Q_ROT;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_REWIND: begin
                // Finish the turn so the original order is restored.
                if (i_sts.idx_at_cnt) begin
                    n_state = w_unload ? S_DISPATCH : S_PUSH;
                end else begin
                    o_cmd.q_op    = Q_ROT;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_PUSH: begin
                o_cmd.q_op = Q_PUSH;
                n_state    = S_TAIL;
            end
            S_TAIL: begin
                o_cmd.q_op = Q_TAIL_HOLD;
                n_state    = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.dispatch = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on dispatch, cleared when the transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.dispatch) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[hw/rtl/priority_ready_queue_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ready queue of up to QUEUE_DEPTH task ids with a priority per task. Each
// command (load, unload, quantum tick, no operation) returns one result with
// the head task, its first-run flag, the entry count and a status code. One
// command is in work at a time; a new one is taken while the previous result
// still waits on the output. How long a command takes is set by the queue,
// a register line that rotates one place per cycle past a single compare
// point at its head: one turn finds the entry, a second moves it. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// Priority ready queue scheduler
// Top level: controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler import prq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_in_if.sink    i_task,
    prq_out_if.source o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer and handshakes.
    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_task.valid),
        .o_in_ready  (i_task.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Queue, tables and result register.
    prq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_opcode           (i_task.opcode),
        .i_task_id          (i_task.task_id),
        .i_task_priority_in (i_task.task_priority_in),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_head_task        (o_result.head_task),
        .o_first_run        (o_result.first_run),
        .o_entries          (o_result.entries),
        .o_status           (o_result.status)
    );

endmodule
`default_nettype wire

[hw/rtl/prq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue port checker
// Concurrent checks on the channels of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module prq_checker import prq_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [ID_W-1:0]      i_head_task,
    input logic                 i_first_run,
    input logic [ENTRIES_W-1:0] i_entries,
    input logic [STATUS_W-1:0]  i_status
);

    // Commands are decoded before the next one is taken.
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command transaction accepted on two consecutive cycles");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_head_task) && $stable(i_first_run)
         && $stable(i_entries) && $stable(i_status)))
        else $error("stalled result changed");

    // An empty head means an empty queue and no first dispatch.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_head_task == '0)) |->
        ((i_entries == '0) && !i_first_run))
        else $error("empty head with entries or first-run flag");

    // A full refusal reports a full, non-empty queue.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL)) |->
        ((i_entries == ENTRIES_W'(QUEUE_DEPTH)) && (i_head_task != '0)))
        else $error("full status with a queue that is not full");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_task.valid),
    .i_in_ready  (i_task.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_head_task (o_result.head_task),
    .i_first_run (o_result.first_run),
    .i_entries   (o_result.entries),
    .i_status    (o_result.status)
);
`default_nettype wire

[tb/tb_priority_ready_queue_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority ready queue scheduler testbench
// Sends load, unload, tick and no-operation commands through the command
// channel in random bursts. A shadow copy of the ready queue predicts every
// dispatch result. Results are taken under a changing stall pattern and
// checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;
    import prq_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_CMDS  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_opcode  op;
        t_task_id id;
        t_prio    prio;
    } t_cmd;

    typedef struct packed {
        t_task_id             head;
        logic                 first;
        logic [ENTRIES_W-1:0] entries;
        t_status              status;
    } t_dispatch;

    logic i_clk;
    logic i_rst_n;

    prq_in_if  task_if ();
    prq_out_if result_if ();

    priority_ready_queue_scheduler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (task_if),
        .o_result (result_if)
    );

    // Shadow state of the ready queue.
    t_task_id ready_q[$];
    t_prio    prio_tab[1:NUM_TASKS];
    t_phase   phase_tab[1:NUM_TASKS];

    t_cmd      queued_cmds[$];
    t_dispatch dispatch_q[$];
    int        error_count = 0;
    int        cycle_count = 0;

    // Driver and receiver state.
    t_cmd        next_cmd;
    int          burst_left = 4;
    int          gap_left   = 0;
    logic [11:0] stall_pat  = '1;
    int          stall_age  = 0;

    // Apply one command to the shadow queue and return the dispatch it causes.
    function automatic t_dispatch predict_dispatch(t_cmd c);
        t_dispatch r;
        int        pos;
        int        pick;
        t_prio     best;
        t_task_id  chosen;
        t_task_id  old_head;
        r.status = ST_OK;
        if (c.op == OP_LOAD || c.op == OP_UNLOAD) begin
            if (c.id < 1 || c.id > NUM_TASKS) begin
                r.status = ST_BAD_ID;
            end else if (c.op == OP_LOAD) begin
                if (ready_q.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ready_q.push_back(c.id);
                    prio_tab[c.id]  = c.prio;
                    phase_tab[c.id] = PH_LOADED;
                end
            end else begin
                // Only the last occurrence of the id is removed.
                pos = -1;
                foreach (ready_q[s]) begin
                    if (ready_q[s] == c.id) pos = s;
                end
                if (pos < 0) begin
                    r.status = ST_NOT_QUEUED;
                end else begin
                    ready_q.delete(pos);
                    phase_tab[c.id] = PH_IDLE;
                end
            end
        end else if (c.op == OP_TICK && ready_q.size() >= 2) begin
            // First highest priority after the head; slot 1 when all are zero.
            pick = 1;
            best = '0;
            for (int s = 1; s < ready_q.size(); s++) begin
                if (prio_tab[ready_q[s]] > best) begin
                    best = prio_tab[ready_q[s]];
                    pick = s;
                end
            end
            chosen = ready_q[pick];
            ready_q.delete(pick);
            old_head = ready_q.pop_front();
            ready_q.push_front(chosen);
            ready_q.push_back(old_head);
        end

        // Dispatch the head and flag its first run since load.
        r.head  = '0;
        r.first = 1'b0;
        if (ready_q.size() > 0) begin
            r.head = ready_q[0];
            if (phase_tab[r.head] == PH_LOADED) begin
                r.first            = 1'b1;
                phase_tab[r.head]  = PH_RUN;
            end
        end
        r.entries = ENTRIES_W'(ready_q.size());
        return r;
    endfunction

    function automatic t_cmd make_cmd(t_opcode op, int id, int pr);
        t_cmd c;
        c.op   = op;
        c.id   = t_task_id'(id);
        c.prio = t_prio'(pr);
        return c;
    endfunction

    // Mostly valid loads, unloads and ticks, with some noise mixed in.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   r;
        int   bad;
        r      = $urandom_range(0, 99);
        c.id   = t_task_id'($urandom_range(1, NUM_TASKS));
        c.prio = ($urandom_range(0, 3) == 0) ? t_prio'(0) : t_prio'($urandom_range(0, 15));
        if (r < 32) begin
            c.op = OP_LOAD;
        end else if (r < 62) begin
            c.op = OP_UNLOAD;
        end else if (r < 92) begin
            c.op = OP_TICK;
            c.id = t_task_id'($urandom_range(0, 15));
        end else if (r < 95) begin
            c.op = OP_NOP;
            c.id = t_task_id'($urandom_range(0, 15));
        end else begin
            c.op = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_UNLOAD;
            bad  = $urandom_range(NUM_TASKS, 15);
            c.id = t_task_id'((bad == NUM_TASKS) ? 0 : bad);
        end
        return c;
    endfunction

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Command driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            task_if.valid            <= 1'b0;
            task_if.opcode           <= '0;
            task_if.task_id          <= '0;
            task_if.task_priority_in <= '0;
        end else if (!task_if.valid || task_if.ready) begin
            if (gap_left > 0) begin
                task_if.valid <= 1'b0;
                gap_left--;
            end else if (queued_cmds.size() > 0) begin
                next_cmd = queued_cmds.pop_front();
                task_if.valid            <= 1'b1;
                task_if.opcode           <= next_cmd.op;
                task_if.task_id          <= next_cmd.id;
                task_if.task_priority_in <= next_cmd.prio;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                end
            end else begin
                task_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: rotating stall pattern, reshuffled every so often.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b1;
        end else begin
            stall_age++;
            if (stall_age >= 97) begin
                stall_age = 0;
                case ($urandom_range(0, 2))
                    0: stall_pat = '1;
                    1: stall_pat = 12'($urandom) | 12'h001;
                    default: stall_pat = 12'($urandom) & 12'($urandom);
                endcase
            end
            stall_pat = {stall_pat[0], stall_pat[11:1]};
            result_if.ready <= stall_pat[0];
        end
    end

    // Monitor: predict on each accepted command, check each accepted result.
    always @(posedge i_clk) begin
        t_dispatch want;
        if (i_rst_n && task_if.valid && task_if.ready) begin
            dispatch_q.push_back(predict_dispatch(make_cmd(t_opcode'(task_if.opcode),
                int'(task_if.task_id), int'(task_if.task_priority_in))));
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (dispatch_q.size() == 0) begin
                $error("unexpected result transaction: head_task %0d", result_if.head_task);
                error_count++;
            end else begin
                want = dispatch_q.pop_front();
                if (result_if.head_task !== want.head) begin
                    $error("head_task: expected %0d, actual %0d", want.head,
                           result_if.head_task);
                    error_count++;
                end
                if (result_if.first_run !== want.first) begin
                    $error("first_run: expected %0d, actual %0d", want.first,
                           result_if.first_run);
                    error_count++;
                end
                if (result_if.entries !== want.entries) begin
                    $error("entries: expected %0d, actual %0d", want.entries,
                           result_if.entries);
                    error_count++;
                end
                if (result_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status,
                           result_if.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: directed corner cases first, then random commands.
    initial begin
        // Empty queue, bad ids and a no operation.
        queued_cmds.push_back(make_cmd(OP_TICK, 0, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 3, 0));
        queued_cmds.push_back(make_cmd(OP_LOAD, 0, 15));
        queued_cmds.push_back(make_cmd(OP_LOAD, 15, 15));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 10, 0));
        queued_cmds.push_back(make_cmd(OP_NOP, 15, 15));
        // Tick on one entry, then a tick where all priorities are zero.
        queued_cmds.push_back(make_cmd(OP_LOAD, 1, 0));
        queued_cmds.push_back(make_cmd(OP_TICK, 15, 0));
        queued_cmds.push_back(make_cmd(OP_LOAD, 2, 0));
        queued_cmds.push_back(make_cmd(OP_LOAD, 3, 0));
        queued_cmds.push_back(make_cmd(OP_TICK, 0, 0));
        // Fill the queue with a duplicate, then overflow it.
        queued_cmds.push_back(make_cmd(OP_LOAD, 9, 15));
        queued_cmds.push_back(make_cmd(OP_LOAD, 2, 8));
        queued_cmds.push_back(make_cmd(OP_LOAD, 8, 15));
        queued_cmds.push_back(make_cmd(OP_LOAD, 5, 1));
        queued_cmds.push_back(make_cmd(OP_TICK, 0, 0));
        queued_cmds.push_back(make_cmd(OP_TICK, 0, 0));
        // Drop the last copy of a duplicate, then empty the queue.
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 2, 0));
        queued_cmds.push_back(make_cmd(OP_TICK, 0, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 6, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 1, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 3, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 9, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 8, 0));
        queued_cmds.push_back(make_cmd(OP_UNLOAD, 2, 0));
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            queued_cmds.push_back(random_cmd());
        end

        // Wait for the driver and the results to drain.
        @(posedge i_clk);
        while (!i_rst_n || queued_cmds.size() > 0 || task_if.valid) @(posedge i_clk);
        while (dispatch_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
